### src/arlm_pkg.sv
// Shared item types and fixed widths for the audio RMS level meter.
`timescale 1ns / 1ps

package arlm_pkg;

  localparam int unsigned SampleW = 24;
  localparam int unsigned SquareW = 2 * SampleW;
  localparam int unsigned SumW    = 64;
  localparam int unsigned MeanW   = 48;
  localparam int unsigned RootW   = 24;

  typedef struct packed {
    logic signed [SampleW-1:0] sample;
    logic                      last;
  } in_item_t;

  typedef struct packed {
    logic [RootW-1:0] rms_level;
    logic             overflow;
  } out_item_t;

  typedef enum logic [1:0] {
    BackIdle,
    BackDiv,
    BackSqrt,
    BackOut
  } back_state_e;

endpackage

### src/arlm_front.sv
// Front end: squares each sample, accumulates the frame and hands closed frames on.
`timescale 1ns / 1ps

module arlm_front #(
  parameter int unsigned MAX_SAMPLES = 65536,
  parameter int unsigned CNT_W       = 17
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  arlm_pkg::in_item_t  in_item_i,
  input  logic                push,
  output logic                full,
  output logic [arlm_pkg::SumW+CNT_W:0] frame_o,
  output logic                frame_push_o,
  input  logic                frame_full_i
);
  import arlm_pkg::*;

  logic [SampleW-1:0] mag;
  logic               s1_vld_q, s1_vld_d;
  logic               s1_last_q;
  logic [SquareW-1:0] s1_sq_q;
  logic               take;
  logic               in_ready;
  logic               sat;
  logic [SumW-1:0]    sum_q, sum_d, sum_acc;
  logic [CNT_W-1:0]   cnt_q, cnt_d, cnt_acc;
  logic               tl_q, tl_d, tl_acc;

  // The most negative sample negates to 2^23, which still fits as unsigned.
  assign mag = in_item_i.sample[SampleW-1] ? (~in_item_i.sample + SampleW'(1))
                                           : in_item_i.sample;

  assign take     = s1_vld_q && (!s1_last_q || !frame_full_i);
  assign in_ready = !s1_vld_q || take;
  assign full     = !in_ready;

  assign sat = (cnt_q == CNT_W'(MAX_SAMPLES));

  always_comb begin
    sum_acc = sum_q;
    cnt_acc = cnt_q;
    tl_acc  = tl_q;
    if (sat) begin
      tl_acc = 1'b1;
    end else begin
      sum_acc = sum_q + {{(SumW-SquareW){1'b0}}, s1_sq_q};
      cnt_acc = cnt_q + CNT_W'(1);
    end
  end

  always_comb begin
    sum_d    = sum_q;
    cnt_d    = cnt_q;
    tl_d     = tl_q;
    s1_vld_d = s1_vld_q;
    if (take) begin
      if (s1_last_q) begin
        sum_d = '0;
        cnt_d = '0;
        tl_d  = 1'b0;
      end else begin
        sum_d = sum_acc;
        cnt_d = cnt_acc;
        tl_d  = tl_acc;
      end
      s1_vld_d = 1'b0;
    end
    if (push && in_ready) begin
      s1_vld_d = 1'b1;
    end
  end

  assign frame_push_o = take && s1_last_q;
  assign frame_o      = {sum_acc, cnt_acc, tl_acc};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      sum_q    <= '0;
      cnt_q    <= '0;
      tl_q     <= 1'b0;
    end else begin
      s1_vld_q <= s1_vld_d;
      sum_q    <= sum_d;
      cnt_q    <= cnt_d;
      tl_q     <= tl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push && in_ready) begin
      s1_sq_q   <= mag * mag;
      s1_last_q <= in_item_i.last;
    end
  end

endmodule

### src/arlm_fifo.sv
// Two-entry queue that carries closed frames from the front end to the back end.
`timescale 1ns / 1ps

module arlm_fifo #(
  parameter int unsigned WIDTH = 82
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [WIDTH-1:0] wr_data_i,
  input  logic             wr_i,
  output logic             full_o,
  output logic [WIDTH-1:0] rd_data_o,
  input  logic             rd_i,
  output logic             empty_o
);
  import arlm_pkg::*;

  logic [WIDTH-1:0] mem_q [2];
  logic             wr_ptr_q, wr_ptr_d;
  logic             rd_ptr_q, rd_ptr_d;
  logic [1:0]       fill_q, fill_d;
  logic             do_wr, do_rd;

  assign full_o    = fill_q[1];
  assign empty_o   = (fill_q == 2'd0);
  assign rd_data_o = mem_q[rd_ptr_q];

  assign do_wr = wr_i && !full_o;
  assign do_rd = rd_i && !empty_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q ^ do_wr;
    rd_ptr_d = rd_ptr_q ^ do_rd;
    fill_d   = fill_q;
    if (do_wr && !do_rd) begin
      fill_d = fill_q + 2'd1;
    end else if (do_rd && !do_wr) begin
      fill_d = fill_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

endmodule

### src/arlm_back.sv
// Back end: divides the frame's sum of squares by its count, takes the root, holds the result.
`timescale 1ns / 1ps

module arlm_back #(
  parameter int unsigned CNT_W = 17
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [arlm_pkg::SumW+CNT_W:0] frame_i,
  input  logic                 frame_empty_i,
  output logic                 frame_pop_o,
  output arlm_pkg::out_item_t  result_o,
  output logic                 empty,
  input  logic                 pop
);
  import arlm_pkg::*;

  localparam int unsigned DivIterW = $clog2(SumW);

  back_state_e state_q, state_d;

  logic [SumW-1:0]     quo_q, quo_d;
  logic [CNT_W-1:0]    div_q, div_d;
  logic [CNT_W-1:0]    rem_q, rem_d;
  logic [DivIterW-1:0] iter_q, iter_d;
  logic                tl_q, tl_d;
  logic [MeanW-1:0]    x_q, x_d;
  logic [MeanW-1:0]    root_q, root_d;
  logic [MeanW-1:0]    bit_q, bit_d;
  logic [CNT_W:0]      trial;
  logic                trial_ge;
  logic [MeanW-1:0]    sq_try;
  logic                sq_ge;
  logic                out_vld_q, out_vld_d;
  out_item_t           out_q, out_d;
  logic                slot_free;

  // Restoring division: one quotient bit per cycle, shifted in as the dividend shifts out.
  assign trial    = {rem_q, quo_q[SumW-1]};
  assign trial_ge = (trial >= {1'b0, div_q});

  assign sq_try = root_q + bit_q;
  assign sq_ge  = (x_q >= sq_try);

  assign slot_free = !out_vld_q || pop;

  always_comb begin
    state_d     = state_q;
    quo_d       = quo_q;
    div_d       = div_q;
    rem_d       = rem_q;
    iter_d      = iter_q;
    tl_d        = tl_q;
    x_d         = x_q;
    root_d      = root_q;
    bit_d       = bit_q;
    out_vld_d   = out_vld_q && !pop;
    out_d       = out_q;
    frame_pop_o = 1'b0;
    case (state_q)
      BackIdle: begin
        if (!frame_empty_i) begin
          frame_pop_o = 1'b1;
          quo_d       = frame_i[SumW+CNT_W:CNT_W+1];
          div_d       = frame_i[CNT_W:1];
          tl_d        = frame_i[0];
          rem_d       = '0;
          iter_d      = '0;
          state_d     = BackDiv;
        end
      end
      BackDiv: begin
        rem_d  = trial_ge ? CNT_W'(trial - {1'b0, div_q}) : trial[CNT_W-1:0];
        quo_d  = {quo_q[SumW-2:0], trial_ge};
        iter_d = iter_q + DivIterW'(1);
        if (iter_q == DivIterW'(SumW - 1)) begin
          x_d     = quo_d[MeanW-1:0];
          root_d  = '0;
          bit_d   = MeanW'(1) << (MeanW - 2);
          state_d = BackSqrt;
        end
      end
      BackSqrt: begin
        if (sq_ge) begin
          x_d    = x_q - sq_try;
          root_d = (root_q >> 1) + bit_q;
        end else begin
          root_d = root_q >> 1;
        end
        bit_d = bit_q >> 2;
        if (bit_q[0]) begin
          state_d = BackOut;
        end
      end
      BackOut: begin
        if (slot_free) begin
          out_vld_d = 1'b1;
          out_d     = '{rms_level: root_q[RootW-1:0], overflow: tl_q};
          state_d   = BackIdle;
        end
      end
      default: begin
        state_d = BackIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= BackIdle;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q  <= quo_d;
    div_q  <= div_d;
    rem_q  <= rem_d;
    iter_q <= iter_d;
    tl_q   <= tl_d;
    x_q    <= x_d;
    root_q <= root_d;
    bit_q  <= bit_d;
    out_q  <= out_d;
  end

  assign empty    = !out_vld_q;
  assign result_o = out_q;

endmodule

### src/audio_rms_level_meter.sv
// Frame RMS level meter for signed 24-bit audio: front accumulator, frame queue, back end.
//
// Input channel: push / full with in_item_i (sample, last). Samples are taken one per
// cycle whenever full is low. Each sample is squared in one register stage and then
// added to the running sum of squares; the count saturates at MAX_SAMPLES and any
// further samples only set the overflow flag. The sample marked last closes the frame.
// Output channel: empty / pop with result_o (rms_level, overflow), one item per frame.
// A closed frame waits in a two-entry queue for the back end, which runs a restoring
// divider (one quotient bit per cycle) and a bitwise square root. The back end works
// on one frame at a time, so short frames fill the queue, and full then rises after the
// sample that closes another frame and holds off the next sample until the queue has room.
// A result waits in the output register while pop is low; the back end starts on the
// next frame meanwhile and holds its answer until the register is free.
// Reset clears the sum, count, overflow flag, queue and output; no clearing pass.
`timescale 1ns / 1ps

module audio_rms_level_meter #(
  parameter int unsigned MAX_SAMPLES = 65536
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  arlm_pkg::in_item_t  in_item_i,
  input  logic                push,
  output logic                full,
  output arlm_pkg::out_item_t result_o,
  output logic                empty,
  input  logic                pop
);
  import arlm_pkg::*;

  localparam int unsigned CntW   = $clog2(MAX_SAMPLES + 1);
  localparam int unsigned FrameW = SumW + CntW + 1;

  logic [FrameW-1:0] frame_wr, frame_rd;
  logic              frame_push, frame_full, frame_pop, frame_empty;

  arlm_front #(
    .MAX_SAMPLES(MAX_SAMPLES),
    .CNT_W      (CntW)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_item_i   (in_item_i),
    .push        (push),
    .full        (full),
    .frame_o     (frame_wr),
    .frame_push_o(frame_push),
    .frame_full_i(frame_full)
  );

  arlm_fifo #(
    .WIDTH(FrameW)
  ) u_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .wr_data_i(frame_wr),
    .wr_i     (frame_push),
    .full_o   (frame_full),
    .rd_data_o(frame_rd),
    .rd_i     (frame_pop),
    .empty_o  (frame_empty)
  );

  arlm_back #(
    .CNT_W(CntW)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .frame_i      (frame_rd),
    .frame_empty_i(frame_empty),
    .frame_pop_o  (frame_pop),
    .result_o     (result_o),
    .empty        (empty),
    .pop          (pop)
  );

endmodule

### src/arlm_checker.sv
// Port-level checks for the RMS level meter, bound to the top level.
`timescale 1ns / 1ps

module arlm_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input arlm_pkg::in_item_t  in_item_i,
  input logic                push,
  input logic                full,
  input arlm_pkg::out_item_t result_o,
  input logic                empty,
  input logic                pop
);
  import arlm_pkg::*;

  // The root of a mean of 24-bit squares never exceeds 2^23.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && result_o.rms_level[RootW-1]) |-> (result_o.rms_level[RootW-2:0] == '0))
    else $error("rms_level above 2^23");

  // Back-pressure on the input only starts right after a frame-closing item is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(full) |-> $past(push && !full && in_item_i.last))
    else $error("full rose without a frame-closing item");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> !empty)
    else $error("result withdrawn before pop");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> $stable(result_o))
    else $error("result changed while stalled");

endmodule

bind audio_rms_level_meter arlm_checker u_arlm_checker (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .in_item_i(in_item_i),
  .push     (push),
  .full     (full),
  .result_o (result_o),
  .empty    (empty),
  .pop      (pop)
);

### verif/audio_rms_level_meter_test.sv
// Self-checking testbench for the audio RMS level meter, with its own frame-level predictor.
`timescale 1ns / 1ps

module audio_rms_level_meter_test;
  import arlm_pkg::*;

  localparam int unsigned MaxSamples = 65536;
  localparam int unsigned RandItems  = 850;
  localparam int unsigned HoldCycles = 400;
  localparam int unsigned StallLimit = 3000;
  localparam int unsigned TailCycles = 200;

  localparam logic signed [SampleW-1:0] MostNeg = 24'sh800000;
  localparam logic signed [SampleW-1:0] MostPos = 24'sh7FFFFF;

  typedef struct packed {
    logic signed [SampleW-1:0] sample;
    logic [16:0]               reps;
    logic                      last;
    logic                      pinned;
    out_item_t                 level;
  } dir_row_t;

  localparam int unsigned DirRows = 14;

  // Rows repeat one sample reps times; last and any fixed result apply to the final one.
  localparam dir_row_t DirTable [DirRows] = '{
    '{24'sd0,       17'd1,     1'b1, 1'b1, '{24'd0,       1'b0}},
    '{MostPos,      17'd1,     1'b1, 1'b1, '{24'd8388607, 1'b0}},
    '{MostNeg,      17'd1,     1'b1, 1'b1, '{24'd8388608, 1'b0}},
    '{24'sd1,       17'd1,     1'b1, 1'b1, '{24'd1,       1'b0}},
    '{-24'sd1,      17'd1,     1'b1, 1'b1, '{24'd1,       1'b0}},
    '{MostPos,      17'd1,     1'b0, 1'b0, '{24'd0,       1'b0}},
    '{MostNeg,      17'd1,     1'b1, 1'b0, '{24'd0,       1'b0}},
    '{24'sd1000,    17'd3,     1'b0, 1'b0, '{24'd0,       1'b0}},
    '{-24'sd3000,   17'd1,     1'b1, 1'b0, '{24'd0,       1'b0}},
    '{MostNeg,      17'd4,     1'b1, 1'b1, '{24'd8388608, 1'b0}},
    '{24'sh555555,  17'd2,     1'b0, 1'b0, '{24'd0,       1'b0}},
    '{-24'sh2AAAAA, 17'd1,     1'b1, 1'b0, '{24'd0,       1'b0}},
    '{24'sd0,       17'd5,     1'b0, 1'b0, '{24'd0,       1'b0}},
    '{24'sd7,       17'd1,     1'b1, 1'b0, '{24'd0,       1'b0}}
  };

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  in_item_t  in_item = '0;
  logic      push = 1'b0;
  logic      full;
  out_item_t result;
  logic      empty;
  logic      pop = 1'b0;

  // Fixed result that travels with the item, used instead of the prediction when set.
  logic      pin_q = 1'b0;
  out_item_t pin_level_q = '0;

  bit          idle_on = 1'b1;
  bit          hold_req = 1'b0;
  int unsigned err_count = 0;
  int unsigned items_taken = 0;
  int unsigned frames_checked = 0;
  int unsigned long_frames = 0;
  int unsigned quiet_cycles = 0;

  logic [SumW-1:0] acc_sum = '0;
  int unsigned     acc_count = 0;
  bit              acc_long = 1'b0;
  out_item_t       pending_levels [$];

  audio_rms_level_meter #(
    .MAX_SAMPLES(MaxSamples)
  ) i_dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_item_i(in_item),
    .push     (push),
    .full     (full),
    .result_o (result),
    .empty    (empty),
    .pop      (pop)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic logic [RootW-1:0] int_sqrt(input logic [SumW-1:0] v);
    logic [SumW-1:0] root;
    logic [SumW-1:0] trial;
    root = '0;
    for (int b = 31; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (trial * trial <= v) begin
        root = trial;
      end
    end
    return root[RootW-1:0];
  endfunction

  // Folds one sample into the frame sums; returns 1 with the level when it closes a frame.
  function automatic bit fold_sample(input in_item_t it, output out_item_t level);
    logic [SampleW-1:0] mag;
    logic [SumW-1:0]    mean;
    level = '0;
    mag = it.sample[SampleW-1] ? (~it.sample + 24'd1) : it.sample;
    if (acc_count >= MaxSamples) begin
      acc_long = 1'b1;
    end else begin
      acc_sum = acc_sum + {40'd0, mag} * {40'd0, mag};
      acc_count++;
    end
    if (!it.last) begin
      return 1'b0;
    end
    mean = acc_sum / acc_count;
    level.rms_level = int_sqrt(mean);
    level.overflow = acc_long;
    acc_sum = '0;
    acc_count = 0;
    acc_long = 1'b0;
    return 1'b1;
  endfunction

  task automatic note_mismatch(input string what, input int unsigned got, input int unsigned want);
    $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
    err_count++;
  endtask

  always @(posedge clk_i) begin
    out_item_t level;
    out_item_t want;
    if (rst_ni) begin
      if (pop && !empty) begin
        if (pending_levels.size() == 0) begin
          note_mismatch("result with nothing pending, rms_level", result.rms_level, 0);
        end else begin
          want = pending_levels.pop_front();
          frames_checked++;
          if (want.overflow) long_frames++;
          if (result.rms_level !== want.rms_level) begin
            note_mismatch("rms_level", result.rms_level, want.rms_level);
          end
          if (result.overflow !== want.overflow) begin
            note_mismatch("overflow", result.overflow, want.overflow);
          end
        end
      end
      if (push && !full) begin
        items_taken++;
        if (fold_sample(in_item, level)) begin
          pending_levels.push_back(pin_q ? pin_level_q : level);
        end
      end
      if ((push && !full) || (pop && !empty)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= StallLimit) begin
          $display("no item moved for %0d cycles, giving up", StallLimit);
          $display("audio_rms_level_meter_test: errors");
          $finish;
        end
      end
    end
  end

  task automatic offer_sample(input logic signed [SampleW-1:0] s, input logic lst,
                              input logic pin, input out_item_t lvl);
    push <= 1'b1;
    in_item <= '{sample: s, last: lst};
    pin_q <= pin;
    pin_level_q <= lvl;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk_i);
    end
  endtask

  task automatic wait_all_levels();
    push <= 1'b0;
    @(posedge clk_i);
    while (pending_levels.size() != 0) @(posedge clk_i);
  endtask

  // Result side: short pop bursts, random stalls, and one long hold-off on request.
  initial begin
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      if (hold_req) begin
        pop <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
        hold_req = 1'b0;
      end else if (idle_on && $urandom_range(0, 3) == 0) begin
        pop <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk_i);
      end else begin
        pop <= 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk_i);
      end
    end
  end

  initial begin
    int unsigned                sent;
    int unsigned                frame_len;
    int unsigned                pick;
    bit                         hold_done;
    bit                         drain_done;
    logic signed [SampleW-1:0]  s;
    logic signed [SampleW-1:0]  frame_base;

    sent = 0;
    hold_done = 1'b0;
    drain_done = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (DirTable[r]) begin
      idle_on = (DirTable[r].reps < 100);
      for (int unsigned k = 0; k < DirTable[r].reps; k++) begin
        offer_sample(DirTable[r].sample, DirTable[r].last && (k == DirTable[r].reps - 1),
                     DirTable[r].pinned && (k == DirTable[r].reps - 1), DirTable[r].level);
      end
    end
    idle_on = 1'b1;

    while (sent < RandItems) begin
      if (!hold_done && sent >= 250) begin
        hold_req = 1'b1;
        hold_done = 1'b1;
      end
      if (!drain_done && sent >= 500) begin
        wait_all_levels();
        drain_done = 1'b1;
      end
      if (sent >= 700) idle_on = 1'b0;

      // Short frames while the result side is held so that the frame queue fills up.
      pick = $urandom_range(0, 99);
      if (hold_req)       frame_len = $urandom_range(1, 2);
      else if (pick < 50) frame_len = $urandom_range(1, 4);
      else if (pick < 85) frame_len = $urandom_range(5, 24);
      else if (pick < 97) frame_len = $urandom_range(25, 80);
      else                frame_len = $urandom_range(81, 300);
      frame_base = SampleW'($urandom());

      for (int unsigned k = 0; k < frame_len; k++) begin
        pick = $urandom_range(0, 9);
        case (pick)
          0: begin
            case ($urandom_range(0, 4))
              0: s = MostNeg;
              1: s = MostPos;
              2: s = '0;
              3: s = -24'sd1;
              default: s = 24'sd1;
            endcase
          end
          1, 2: begin
            s = SampleW'($urandom_range(0, 255));
            if ($urandom_range(0, 1) == 1) s = -s;
          end
          3: s = frame_base;
          default: s = SampleW'($urandom());
        endcase
        offer_sample(s, k == frame_len - 1, 1'b0, '0);
        sent++;
      end
    end

    wait_all_levels();
    repeat (TailCycles) @(posedge clk_i);
    $display("%0d samples taken in, %0d frame levels checked, %0d of them with overflow.",
             items_taken, frames_checked, long_frames);
    $display("Covered extremes, mixed frame lengths, a long result hold-off and a full drain.");
    if (err_count == 0) begin
      $display("audio_rms_level_meter_test: clean");
    end else begin
      $display("audio_rms_level_meter_test: errors");
    end
    $finish;
  end

endmodule

### audio_rms_level_meter.f
src/arlm_pkg.sv
src/arlm_front.sv
src/arlm_fifo.sv
src/arlm_back.sv
src/audio_rms_level_meter.sv
src/arlm_checker.sv
verif/audio_rms_level_meter_test.sv
